### rtl/swm_pkg.sv
// shared constants for the sliding window maximum block
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;
    localparam int MAX_WINDOW = 64;                // power of two
    localparam int AW         = $clog2(MAX_WINDOW);
    localparam int CW         = AW + 1;
    localparam int DATA_W     = 32;
    localparam int WL_W       = 7;
    localparam logic [WL_W-1:0] WL_RESET = WL_W'(3);

    typedef logic [AW-1:0]     addr_t;
    typedef logic [CW-1:0]     cnt_t;
    typedef logic [DATA_W-1:0] data_t;
endpackage
`default_nettype wire

### rtl/sliding_window_maximum.sv
// sliding window maximum over a monotonic deque held in ram
//
// Each accepted item carries one signed sample; once window_len samples of the
// current sequence have been seen, each item gives one result, the maximum of
// the last window_len samples (window_len 0 acts as 1, above 64 as 64). An item
// passes through a retire step, a pop step for every deque entry that the new
// sample drops from the back, a pop step that writes the sample, and an output
// step, which waits, if the item gives a result, while the result before it is
// still unaccepted. The pop loop walks the deque ram, which has a single write
// port and a registered read, one entry per cycle. A new item is taken while a
// result still waits in the output register. start_req empties the window before
// its sample is taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_maximum
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [6:0]           cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   sample,
    input  wire logic                 start_req,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        window_max
);
    import swm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RETIRE = 2'd1;
    localparam logic [1:0] S_POP    = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [WL_W-1:0] wl_reg;
    addr_t           head_reg, head_next;
    cnt_t            count_reg, count_next;
    cnt_t            seen_reg, seen_next;
    addr_t           wp_reg, wp_next;
    logic            retire_en_reg, retire_en_next;
    logic            emit_reg, emit_next;
    logic            out_valid_reg, out_valid_next;
    data_t           sample_reg;
    data_t           window_max_reg, window_max_next;
    logic            load_sample;
    cnt_t            k;

    // delay line ram
    data_t dl_mem [MAX_WINDOW];
    data_t dl_rd_reg;
    logic  dl_we, dl_re;
    addr_t dl_waddr, dl_raddr;

    // deque ram, one write port, two read ports
    data_t dq_mem [MAX_WINDOW];
    data_t dq_a_reg, dq_b_reg;
    logic  dq_we, dq_re_a, dq_re_b;
    addr_t dq_waddr, dq_addr_a, dq_addr_b;

    // scratch
    addr_t h0, h1;
    cnt_t  c0, c1;
    logic  ret0;

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_waddr] <= sample;
        end
        if (dl_re)
        begin
            dl_rd_reg <= dl_mem[dl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dq_we)
        begin
            dq_mem[dq_waddr] <= sample_reg;
        end
        if (dq_re_a)
        begin
            dq_a_reg <= dq_mem[dq_addr_a];
        end
        if (dq_re_b)
        begin
            dq_b_reg <= dq_mem[dq_addr_b];
        end
    end

    always_comb
    begin
        if (wl_reg == '0)
        begin
            k = CW'(1);
        end
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
        begin
            k = CW'(MAX_WINDOW);
        end
        else
        begin
            k = CW'(wl_reg);
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        seen_next       = seen_reg;
        wp_next         = wp_reg;
        retire_en_next  = retire_en_reg;
        emit_next       = emit_reg;
        out_valid_next  = out_valid_reg;
        window_max_next = window_max_reg;
        load_sample     = 1'b0;
        dl_we           = 1'b0;
        dl_re           = 1'b0;
        dl_waddr        = wp_reg;
        dl_raddr        = wp_reg - k[AW-1:0];
        dq_we           = 1'b0;
        dq_re_a         = 1'b0;
        dq_re_b         = 1'b0;
        dq_waddr        = head_reg;
        dq_addr_a       = head_reg;
        dq_addr_b       = head_reg;
        h0              = head_reg;
        c0              = count_reg;
        h1              = head_reg;
        c1              = count_reg;
        ret0            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_req)
                    begin
                        h0        = '0;
                        c0        = '0;
                        seen_next = '0;
                    end
                    else
                    begin
                        seen_next = seen_reg;
                    end
                    ret0           = (seen_next >= k);
                    retire_en_next = ret0;
                    dl_re          = ret0;
                    dl_we          = 1'b1;
                    wp_next        = wp_reg + AW'(1);
                    if (seen_next < k)
                    begin
                        seen_next = seen_next + CW'(1);
                    end
                    else
                    begin
                        seen_next = k;
                    end
                    emit_next   = (seen_next == k);
                    dq_re_a     = 1'b1;
                    dq_addr_a   = h0;
                    dq_re_b     = (c0 != '0);
                    dq_addr_b   = h0 + c0[AW-1:0] - AW'(1);
                    head_next   = h0;
                    count_next  = c0;
                    load_sample = 1'b1;
                    state_next  = S_RETIRE;
                end
            end
            S_RETIRE:
            begin
                // front leaves the window when it equals the retiring sample
                if (retire_en_reg && count_reg != '0 && dq_a_reg == dl_rd_reg)
                begin
                    head_next  = head_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                if (count_reg != '0 && $signed(dq_b_reg) < $signed(sample_reg))
                begin
                    count_next = count_reg - CW'(1);
                    dq_re_b    = 1'b1;
                    dq_addr_b  = head_reg + count_reg[AW-1:0] - AW'(2);
                end
                else
                begin
                    if (count_reg == CW'(MAX_WINDOW))
                    begin
                        h1 = head_reg + AW'(1);
                        c1 = count_reg - CW'(1);
                    end
                    dq_we      = 1'b1;
                    dq_waddr   = h1 + c1[AW-1:0];
                    dq_re_a    = 1'b1;
                    dq_addr_a  = h1;
                    head_next  = h1;
                    count_next = c1 + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!emit_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // a lone entry is the sample just written
                    window_max_next = (count_reg == CW'(1)) ? sample_reg : dq_a_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wl_reg        <= WL_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            seen_reg      <= '0;
            wp_reg        <= '0;
            retire_en_reg <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            wp_reg        <= wp_next;
            retire_en_reg <= retire_en_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                wl_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sample)
        begin
            sample_reg <= sample;
        end
        window_max_reg <= window_max_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOW))
        else $error("deque count beyond capacity");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_RETIRE)
        else $error("accepted item did not enter retire step");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> count_reg != '0)
        else $error("deque empty after push");

    a_result_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT && $past(emit_reg))
        else $error("result without a full window");
endmodule
`default_nettype wire

### tb/sliding_window_maximum_tb.sv
// testbench for sliding_window_maximum: predicted window maxima checked item by item
`timescale 1ns / 1ps
module sliding_window_maximum_tb;
    import swm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;

    typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_FALLING, PAT_RISING, PAT_EXTREME} pattern_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [WL_W-1:0]     cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [31:0]  sample = '0;
    logic                start_req = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [31:0]  window_max;

    // predictor state
    data_t               hist_mem [MAX_WINDOW];
    addr_t               hist_wp;
    data_t               mono_vals [MAX_WINDOW];
    addr_t               mono_head;
    cnt_t                mono_cnt;
    cnt_t                seen_cnt;
    logic [WL_W-1:0]     win_len_reg;
    data_t               pending_max_q [$];

    int                  send_idle_pct = 30;
    int                  recv_idle_pct = 30;
    int                  error_count = 0;
    int                  items_sent = 0;
    int                  results_checked = 0;
    int                  len_writes = 0;
    int                  cycle_count = 0;

    sliding_window_maximum i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .start_req   (start_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_max  (window_max)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sliding_window_maximum_tb failed");
            $finish;
        end
    end

    task automatic track_window_max(input data_t s, input logic st);
        cnt_t  k;
        addr_t old_idx;
        addr_t tail;
        logic  dropping;
        k = (win_len_reg == '0) ? cnt_t'(1) :
            (int'(win_len_reg) > MAX_WINDOW) ? cnt_t'(MAX_WINDOW) : cnt_t'(win_len_reg);
        if (st)
        begin
            mono_head = '0;
            mono_cnt  = '0;
            seen_cnt  = '0;
        end
        // retire the sample leaving the window
        if (seen_cnt >= k)
        begin
            old_idx = hist_wp - addr_t'(k);
            if (mono_cnt != '0 && mono_vals[mono_head] == hist_mem[old_idx])
            begin
                mono_head = mono_head + addr_t'(1);
                mono_cnt  = mono_cnt - cnt_t'(1);
            end
        end
        dropping = 1'b1;
        while (dropping && mono_cnt != '0)
        begin
            tail = mono_head + addr_t'(mono_cnt - cnt_t'(1));
            if ($signed(mono_vals[tail]) < $signed(s))
                mono_cnt = mono_cnt - cnt_t'(1);
            else
                dropping = 1'b0;
        end
        // full deque drops its front
        if (mono_cnt == cnt_t'(MAX_WINDOW))
        begin
            mono_head = mono_head + addr_t'(1);
            mono_cnt  = mono_cnt - cnt_t'(1);
        end
        tail = mono_head + addr_t'(mono_cnt);
        mono_vals[tail] = s;
        mono_cnt = mono_cnt + cnt_t'(1);
        hist_mem[hist_wp] = s;
        hist_wp = hist_wp + addr_t'(1);
        if (seen_cnt < k)
            seen_cnt = seen_cnt + cnt_t'(1);
        if (seen_cnt > k)
            seen_cnt = k;
        if (seen_cnt >= k)
            pending_max_q = {pending_max_q, mono_vals[mono_head]};
    endtask

    always @(posedge clk)
    begin : check_results
        data_t exp_max;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_max_q.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected window_max %0d with nothing pending", window_max);
                error_count++;
            end
            else
            begin
                exp_max = pending_max_q[0];
                pending_max_q.delete(0);
                results_checked++;
                if (window_max !== exp_max)
                begin
                    if (error_count < 10)
                        $display("window_max mismatch: expected %0d, got %0d",
                                 $signed(exp_max), window_max);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : drive_out_ready
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_sample(input data_t s, input logic st);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= s;
        start_req <= st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        track_window_max(s, st);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_max_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_len(input logic [WL_W-1:0] len);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_len_reg = len;
        len_writes++;
    endtask

    function automatic data_t next_sample(input pattern_t pat, input data_t prev);
        case (pat)
            PAT_NARROW:  return data_t'($urandom_range(0, 6)) - 32'd3;
            PAT_FALLING: return prev - data_t'($urandom_range(0, 3));
            PAT_RISING:  return prev + data_t'($urandom_range(0, 3));
            PAT_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            default:     return data_t'($urandom);
        endcase
    endfunction

    // reset length of 3, extremes of the sample range
    task automatic test_reset_default();
        send_sample(32'h7fff_ffff, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
    endtask

    // length zero acts as one, length one, restarts while filling, equal values
    task automatic test_short_windows();
        write_window_len(7'd0);
        send_sample(32'h7fff_ffff, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        write_window_len(7'd1);
        send_sample(32'hffff_ffff, 1'b1);
        send_sample(32'h0000_0001, 1'b0);
        write_window_len(7'd2);
        send_sample(32'd5, 1'b1);
        send_sample(32'd4, 1'b1);
        send_sample(32'd4, 1'b0);
        send_sample(32'd4, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd9, 1'b1);
        send_sample(-32'sd9, 1'b0);
        send_sample(32'd2, 1'b0);
    endtask

    // length above the maximum acts as the maximum
    task automatic test_full_window();
        data_t s;
        write_window_len(7'd127);
        s = data_t'($urandom);
        for (int i = 0; i < 70; i++)
        begin
            s = next_sample(PAT_RANDOM, s);
            send_sample(s, i == 0);
        end
    endtask

    // length changes without a restart, including a full deque on append
    task automatic test_length_change();
        data_t s;
        write_window_len(7'd64);
        s = 32'h4000_0000;
        for (int i = 0; i < 64; i++)
        begin
            s = s - data_t'($urandom_range(1, 3));
            send_sample(s, i == 0);
        end
        write_window_len(7'd2);
        for (int i = 0; i < 8; i++)
        begin
            s = s - data_t'($urandom_range(1, 3));
            send_sample(s, 1'b0);
        end
        write_window_len(7'd10);
        for (int i = 0; i < 20; i++)
            send_sample(next_sample(PAT_NARROW, s), 1'b0);
        write_window_len(7'd65);
        for (int i = 0; i < 70; i++)
        begin
            s = next_sample(pattern_t'($urandom_range(0, 4)), s);
            send_sample(s, 1'b0);
        end
    endtask

    task automatic test_random_sequences(input int item_target, input logic allow_idle);
        int       sent;
        int       num_seq;
        int       seq_len;
        int       eff_len;
        logic [WL_W-1:0] len;
        pattern_t pat;
        data_t    s;
        sent = 0;
        while (sent < item_target)
        begin
            case ($urandom_range(0, 9))
                0:       len = 7'd0;
                1:       len = 7'd1;
                2, 3, 4: len = WL_W'($urandom_range(2, 8));
                5, 6:    len = WL_W'($urandom_range(9, 64));
                7:       len = 7'd64;
                8:       len = WL_W'($urandom_range(65, 127));
                default: len = WL_W'($urandom_range(1, 16));
            endcase
            write_window_len(len);
            eff_len = (len == '0) ? 1 : (int'(len) > MAX_WINDOW) ? MAX_WINDOW : int'(len);
            if (allow_idle)
            begin
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
                recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            end
            num_seq = $urandom_range(1, 4);
            for (int q = 0; q < num_seq && sent < item_target; q++)
            begin
                seq_len = $urandom_range(1, 2 * eff_len + 6);
                pat = pattern_t'($urandom_range(0, 4));
                s = data_t'($urandom);
                for (int i = 0; i < seq_len; i++)
                begin
                    s = next_sample(pat, s);
                    // a phase sometimes carries on the old sequence, and stray restarts occur
                    if (i == 0)
                        send_sample(s, !(q == 0 && $urandom_range(0, 3) == 0));
                    else
                        send_sample(s, $urandom_range(0, 39) == 0);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : run_tests
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            hist_mem[i]  = '0;
            mono_vals[i] = '0;
        end
        hist_wp     = '0;
        mono_head   = '0;
        mono_cnt    = '0;
        seen_cnt    = '0;
        win_len_reg = WL_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_default();
        test_short_windows();
        test_full_window();
        test_length_change();
        test_random_sequences(650, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(150, 1'b0);
        settle();

        $display("sent %0d items over %0d window length settings, checked %0d maxima",
                 items_sent, len_writes, results_checked);
        $display("%0d mismatches, %0d maxima still pending", error_count, pending_max_q.size());
        if (error_count == 0 && pending_max_q.size() == 0)
            $display("sliding_window_maximum_tb passed");
        else
            $display("sliding_window_maximum_tb failed");
        $finish;
    end
endmodule
